@@ hw/rtl/topk_sorted_box_nms_top_assert.svh @@
// Assertion macros for the top-K box NMS block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TOPK_SORTED_BOX_NMS_TOP_ASSERT_SVH
`define TOPK_SORTED_BOX_NMS_TOP_ASSERT_SVH

// Plain property, sampled on clk, off during reset.
`define TSNMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define TSNMS_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/tsnms_pkg.sv @@
// Shared types and constants for the top-K box NMS block.
// No dependencies.
package tsnms_pkg;

    localparam int MAX_TOP_K_DEF = 64;
    localparam int TOPK_W        = 7;
    localparam int NMS_W         = 9;
    localparam int RANK_W        = 6;
    localparam int AREA_W        = 26;

    localparam logic [1:0] CFG_SCORE_THRESH = 2'd0;
    localparam logic [1:0] CFG_TOP_K        = 2'd1;
    localparam logic [1:0] CFG_NMS_THRESH   = 2'd2;

    localparam logic [15:0]       SCORE_THRESH_RST = 16'd39322;
    localparam logic [TOPK_W-1:0] TOP_K_RST        = 7'd64;
    localparam logic [NMS_W-1:0]  NMS_THRESH_RST   = 9'd77;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [12:0]        w;
        logic [12:0]        h;
    } box_t;

    typedef struct packed {
        box_t        box;
        logic [15:0] score;
        logic [3:0]  cls;
        logic [1:0]  color;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   pass;
        logic   frame_end;
    } item_t;

    typedef struct packed {
        entry_t            ent;
        logic [RANK_W-1:0] rank;
        logic              last;
        logic              none;
    } result_t;

    typedef struct packed {
        logic [15:0]       score_thresh;
        logic [TOPK_W-1:0] top_k;
        logic [NMS_W-1:0]  nms_thresh;
    } cfg_t;

endpackage

@@ hw/rtl/tsnms_ifs.sv @@
// Handshake channel interfaces: proposals in, results out, register writes.
// No dependencies.
interface tsnms_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [12:0]        box_w;
    logic [12:0]        box_h;
    logic [15:0]        score;
    logic [3:0]         class_tag;
    logic [1:0]         color_tag;
    logic               frame_end;

    modport source (output valid, box_x, box_y, box_w, box_h, score, class_tag,
                    color_tag, frame_end, input ready);
    modport sink (input valid, box_x, box_y, box_w, box_h, score, class_tag,
                  color_tag, frame_end, output ready);
endinterface

interface tsnms_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] kept_x;
    logic signed [15:0] kept_y;
    logic [12:0]        kept_w;
    logic [12:0]        kept_h;
    logic [15:0]        kept_score;
    logic [3:0]         kept_class;
    logic [1:0]         kept_color;
    logic [5:0]         kept_rank;
    logic               last_of_run;
    logic               none_kept;

    modport source (output valid, kept_x, kept_y, kept_w, kept_h, kept_score,
                    kept_class, kept_color, kept_rank, last_of_run, none_kept,
                    input ready);
    modport sink (input valid, kept_x, kept_y, kept_w, kept_h, kept_score,
                  kept_class, kept_color, kept_rank, last_of_run, none_kept,
                  output ready);
endinterface

interface tsnms_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/topk_sorted_box_nms_top.sv @@
// Top level of the top-K sorted box NMS block: config registers, front, back.
// Depends on tsnms_pkg, tsnms_ifs, tsnms_front, tsnms_back.
//
// Proposals stream in one word per cycle while the block is idle. Each word
// whose score reaches score_thresh is placed into a row of MAX_TOP_K sorted
// cells (equal scores keep arrival order; the list holds min(top_k, MAX_TOP_K)
// entries). On the word flagged frame_end the block runs greedy suppression
// in rank order: each candidate is checked against every box kept so far,
// one pair at a time through a shared IoU unit (extents, products,
// threshold multiply, compare), reading kept boxes from a small RAM.
// Input is held off during that pass beyond a 2-word queue. Results come out
// in rank order with last_of_run on the final word, or one none_kept word
// when nothing survives. Write registers only while the block is idle.
module topk_sorted_box_nms_top
    import tsnms_pkg::*;
#(
    parameter int MaxTopK = MAX_TOP_K_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tsnms_in_if.sink     prop_in,
    tsnms_out_if.source  res_out,
    tsnms_cfg_if.sink    cfg
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid, q_pop;
    item_t q_item;

    // register writes are always taken; unknown index is ignored
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SCORE_THRESH: cfg_next.score_thresh = cfg.data;
                CFG_TOP_K:        cfg_next.top_k        = cfg.data[TOPK_W-1:0];
                CFG_NMS_THRESH:   cfg_next.nms_thresh   = cfg.data[NMS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_thresh <= SCORE_THRESH_RST;
            cfg_reg.top_k        <= TOP_K_RST;
            cfg_reg.nms_thresh   <= NMS_THRESH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // threshold check and decoupling queue
    tsnms_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .prop_in      (prop_in),
        .score_thresh (cfg_reg.score_thresh),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // ranking, suppression and result register
    tsnms_back #(
        .MaxTopK (MaxTopK)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .res_out (res_out)
    );

endmodule

@@ hw/rtl/tsnms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsnms_ram #(
    parameter int Width = 8,
    parameter int Depth = 64,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [Width-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/tsnms_front.sv @@
// Front end: takes proposals, applies the score threshold, queues them (2 deep).
// Depends on tsnms_pkg and tsnms_ifs.
module tsnms_front
    import tsnms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tsnms_in_if.sink    prop_in,
    input  logic [15:0] score_thresh,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    item_t      new_item;

    assign prop_in.ready = (cnt_reg != 2'd2);
    assign push          = prop_in.valid && prop_in.ready;
    assign q_valid       = (cnt_reg != 2'd0);
    assign pop           = q_pop && q_valid;
    assign q_item        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.ent.box.x = prop_in.box_x;
        new_item.ent.box.y = prop_in.box_y;
        new_item.ent.box.w = prop_in.box_w;
        new_item.ent.box.h = prop_in.box_h;
        new_item.ent.score = prop_in.score;
        new_item.ent.cls   = prop_in.class_tag;
        new_item.ent.color = prop_in.color_tag;
        new_item.pass      = (prop_in.score >= score_thresh);
        new_item.frame_end = prop_in.frame_end;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ hw/rtl/tsnms_back.sv @@
// Back end: sorted top-K cell row, sequential IoU suppression, result register.
// Depends on tsnms_pkg, tsnms_ifs and tsnms_ram.
module tsnms_back
    import tsnms_pkg::*;
#(
    parameter int MaxTopK = MAX_TOP_K_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    tsnms_out_if.source res_out
);

    localparam int CW   = $clog2(MaxTopK + 1);
    localparam int IW   = (MaxTopK > 1) ? $clog2(MaxTopK) : 1;
    localparam int CAPW = (CW > TOPK_W) ? CW : TOPK_W;
    localparam logic [CAPW-1:0] MaxCap = CAPW'(MaxTopK);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_S1    = 4'd3;
    localparam logic [3:0] S_S2    = 4'd4;
    localparam logic [3:0] S_S3    = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_KEEP  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] kept_reg, kept_next;

    entry_t cell_reg  [MaxTopK];
    entry_t cell_next [MaxTopK];
    entry_t prev_cell [MaxTopK];
    entry_t nxt_cell  [MaxTopK];
    logic [MaxTopK-1:0] ge, lt, prev_ge;

    logic [CAPW-1:0] cap_w;
    logic [CW-1:0]   cap, count_eff;
    logic            discard, ins, shift;

    entry_t              cand_reg, cand_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [AREA_W-1:0]   area_a_reg, area_a_next;
    logic [12:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic                ovl_reg, ovl_next;
    logic [AREA_W-1:0]   inter_reg, inter_next, area_b_reg, area_b_next;
    logic [AREA_W+7:0]   lhs_reg, lhs_next;
    logic [AREA_W+NMS_W:0] prod_reg, prod_next;
    logic [AREA_W:0]     uni;

    result_t pend_reg, pend_next;
    logic    pend_v_reg, pend_v_next;
    result_t out_reg, out_next;
    logic    out_v_reg, out_v_next;
    logic    slot_free;

    logic ram_we;
    box_t rd_box;

    logic signed [16:0] axe, aye, bxe, bye, ar, ad, br, bd, l, r, t, d;
    logic signed [16:0] dxw, dyw;

    // capacity and effective fill
    assign cap_w     = (CAPW'(cfg.top_k) < MaxCap) ? CAPW'(cfg.top_k) : MaxCap;
    assign cap       = cap_w[CW-1:0];
    assign count_eff = (count_reg < cap) ? count_reg : cap;

    genvar k;
    generate
        for (k = 0; k < MaxTopK; k++)
        begin : g_cell
            assign lt[k] = (CW'(k) < count_eff);
            assign ge[k] = lt[k] && (cell_reg[k].score >= q_item.ent.score);
            if (k == 0)
            begin : g_head
                assign prev_ge[k]   = 1'b1;
                assign prev_cell[k] = cell_reg[k];
            end
            else
            begin : g_body
                assign prev_ge[k]   = ge[k-1];
                assign prev_cell[k] = cell_reg[k-1];
            end
            if (k == MaxTopK - 1)
            begin : g_tail
                assign nxt_cell[k] = cell_reg[k];
            end
            else
            begin : g_up
                assign nxt_cell[k] = cell_reg[k+1];
            end
        end
    endgenerate

    // newcomer ranks below a full list
    assign discard = (&(ge | ~lt)) && (count_eff == cap);
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign ins     = q_pop && q_item.pass && !discard;
    assign shift   = (state_reg == S_LOAD) && (i_reg != count_eff);

    always_comb
    begin
        for (int n = 0; n < MaxTopK; n++)
        begin
            if (ins && !ge[n])
            begin
                cell_next[n] = prev_ge[n] ? q_item.ent : prev_cell[n];
            end
            else if (shift)
            begin
                cell_next[n] = nxt_cell[n];
            end
            else
            begin
                cell_next[n] = cell_reg[n];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < MaxTopK; n++)
        begin
            cell_reg[n] <= cell_next[n];
        end
    end

    tsnms_ram #(
        .Width ($bits(box_t)),
        .Depth (MaxTopK),
        .AddrW (IW)
    ) u_kept_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (kept_reg[IW-1:0]),
        .wr_data (cand_reg.box),
        .rd_addr (j_reg[IW-1:0]),
        .rd_data (rd_box)
    );

    // overlap extents
    always_comb
    begin
        axe = {cand_reg.box.x[15], cand_reg.box.x};
        aye = {cand_reg.box.y[15], cand_reg.box.y};
        bxe = {rd_box.x[15], rd_box.x};
        bye = {rd_box.y[15], rd_box.y};
        ar  = axe + $signed({4'b0, cand_reg.box.w});
        ad  = aye + $signed({4'b0, cand_reg.box.h});
        br  = bxe + $signed({4'b0, rd_box.w});
        bd  = bye + $signed({4'b0, rd_box.h});
        l   = (axe > bxe) ? axe : bxe;
        t   = (aye > bye) ? aye : bye;
        r   = (ar < br) ? ar : br;
        d   = (ad < bd) ? ad : bd;
        dxw = r - l;
        dyw = d - t;
    end

    assign slot_free = !out_v_reg || res_out.ready;
    assign uni = {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter_reg};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        kept_next   = kept_reg;
        cand_next   = cand_reg;
        rank_next   = rank_reg;
        area_a_next = area_a_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        ovl_next    = ovl_reg;
        inter_next  = inter_reg;
        area_b_next = area_b_reg;
        lhs_next    = lhs_reg;
        prod_next   = prod_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        out_next    = out_reg;
        out_v_next  = (out_v_reg && res_out.ready) ? 1'b0 : out_v_reg;
        ram_we      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    // a passing word trims the list to capacity even when discarded
                    if (q_item.pass)
                    begin
                        count_next = (ins && count_eff < cap) ? count_eff + CW'(1)
                                                              : count_eff;
                    end
                    if (q_item.frame_end)
                    begin
                        i_next      = '0;
                        kept_next   = '0;
                        pend_v_next = 1'b0;
                        state_next  = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                if (i_reg == count_eff)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cand_next   = cell_reg[0];
                    rank_next   = RANK_W'(i_reg);
                    area_a_next = cell_reg[0].box.w * cell_reg[0].box.h;
                    j_next      = '0;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                state_next = (j_reg == kept_reg) ? S_KEEP : S_S1;
            end
            S_S1:
            begin
                ovl_next   = (r > l) && (d > t);
                dx_next    = dxw[12:0];
                dy_next    = dyw[12:0];
                state_next = S_S2;
            end
            S_S2:
            begin
                inter_next  = ovl_reg ? dx_reg * dy_reg : '0;
                area_b_next = rd_box.w * rd_box.h;
                state_next  = S_S3;
            end
            S_S3:
            begin
                lhs_next   = {inter_reg, 8'd0};
                prod_next  = cfg.nms_thresh * uni;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if ({2'b0, lhs_reg} > prod_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_LOAD;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_KEEP:
            begin
                if (!pend_v_reg || slot_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next   = pend_reg;
                        out_v_next = 1'b1;
                    end
                    ram_we         = 1'b1;
                    kept_next      = kept_reg + CW'(1);
                    i_next         = i_reg + CW'(1);
                    pend_next.ent  = cand_reg;
                    pend_next.rank = rank_reg;
                    pend_next.last = 1'b0;
                    pend_next.none = 1'b0;
                    pend_v_next    = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next      = '0;
                        out_next.last = 1'b1;
                        out_next.none = 1'b1;
                    end
                    out_v_next  = 1'b1;
                    pend_v_next = 1'b0;
                    count_next  = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            kept_reg   <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            kept_reg   <= kept_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        rank_reg   <= rank_next;
        area_a_reg <= area_a_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        ovl_reg    <= ovl_next;
        inter_reg  <= inter_next;
        area_b_reg <= area_b_next;
        lhs_reg    <= lhs_next;
        prod_reg   <= prod_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign res_out.valid       = out_v_reg;
    assign res_out.kept_x      = out_reg.ent.box.x;
    assign res_out.kept_y      = out_reg.ent.box.y;
    assign res_out.kept_w      = out_reg.ent.box.w;
    assign res_out.kept_h      = out_reg.ent.box.h;
    assign res_out.kept_score  = out_reg.ent.score;
    assign res_out.kept_class  = out_reg.ent.cls;
    assign res_out.kept_color  = out_reg.ent.color;
    assign res_out.kept_rank   = out_reg.rank;
    assign res_out.last_of_run = out_reg.last;
    assign res_out.none_kept   = out_reg.none;

endmodule

@@ hw/rtl/tsnms_checker.sv @@
// Port-level checks for the top-K box NMS block, bound to the top level.
// Depends on topk_sorted_box_nms_top_assert.svh.
`include "topk_sorted_box_nms_top_assert.svh"

module tsnms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_frame_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_x,
    input logic [15:0] out_score,
    input logic [5:0]  out_rank,
    input logic        out_last,
    input logic        out_none
);

    logic       in_end_acc, out_acc;
    logic [7:0] frames_reg;
    logic       in_run_reg;
    logic [5:0] prev_rank_reg;
    logic [29:0] out_word;

    assign in_end_acc = in_valid && in_ready && in_frame_end;
    assign out_acc    = out_valid && out_ready;
    assign out_word   = {out_x, out_rank, out_last, out_none, out_score[5:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= 8'd0;
            in_run_reg    <= 1'b0;
            prev_rank_reg <= 6'd0;
        end
        else
        begin
            frames_reg <= frames_reg + {7'd0, in_end_acc} - {7'd0, out_acc && out_last};
            if (out_acc)
            begin
                in_run_reg    <= !out_last;
                prev_rank_reg <= out_rank;
            end
        end
    end

    `TSNMS_IMPLY(a_none_empty, out_valid && out_none, out_last && out_x == 16'd0 && out_score == 16'd0 && out_rank == 6'd0, "empty result not clean")
    `TSNMS_IMPLY(a_frame_owed, out_valid, frames_reg != 8'd0, "result without a frame end")
    `TSNMS_IMPLY(a_rank_rises, out_acc && in_run_reg, out_rank > prev_rank_reg, "rank not rising")
    `TSNMS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled word changed")

endmodule

bind topk_sorted_box_nms_top tsnms_checker u_tsnms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (prop_in.valid),
    .in_ready     (prop_in.ready),
    .in_frame_end (prop_in.frame_end),
    .out_valid    (res_out.valid),
    .out_ready    (res_out.ready),
    .out_x        (res_out.kept_x),
    .out_score    (res_out.kept_score),
    .out_rank     (res_out.kept_rank),
    .out_last     (res_out.last_of_run),
    .out_none     (res_out.none_kept)
);

@@ verif/topk_sorted_box_nms_tb_scoreboard.sv @@
// Frame ranking and suppression predictor plus result checker for the box NMS block.
// Depends on tsnms_pkg.
package tsnms_tb_sb_pkg;
    import tsnms_pkg::*;

    localparam int LIST_DEPTH = MAX_TOP_K_DEF;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [12:0]        w;
        logic [12:0]        h;
        logic [15:0]        score;
        logic [3:0]         cls;
        logic [1:0]         color;
        logic               frame_end;
    } proposal_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [12:0]        w;
        logic [12:0]        h;
        logic [15:0]        score;
        logic [3:0]         cls;
        logic [1:0]         color;
        logic [5:0]         rank;
        logic               last;
        logic               none;
    } kept_box_t;

    class nms_scoreboard;
        logic [15:0]       score_thresh;
        logic [TOPK_W-1:0] top_k;
        logic [NMS_W-1:0]  nms_thresh;
        proposal_t         ranked[LIST_DEPTH];
        int                ranked_n;
        kept_box_t         pending_boxes[$];
        int                errors;

        function new();
            score_thresh = SCORE_THRESH_RST;
            top_k        = TOP_K_RST;
            nms_thresh   = NMS_THRESH_RST;
            ranked_n     = 0;
            errors       = 0;
        endfunction

        function int list_cap();
            return (top_k < LIST_DEPTH) ? int'(top_k) : LIST_DEPTH;
        endfunction

        function longint overlap(proposal_t a, proposal_t b);
            longint l, r, t, d;
            l = (a.x > b.x) ? a.x : b.x;
            r = ((a.x + longint'(a.w)) < (b.x + longint'(b.w))) ?
                (a.x + longint'(a.w)) : (b.x + longint'(b.w));
            t = (a.y > b.y) ? a.y : b.y;
            d = ((a.y + longint'(a.h)) < (b.y + longint'(b.h))) ?
                (a.y + longint'(a.h)) : (b.y + longint'(b.h));
            if (r <= l || d <= t)
                return 0;
            return (r - l) * (d - t);
        endfunction

        // Note one accepted proposal; on frame end, queue the frame's survivors.
        function void note_proposal(proposal_t p);
            int cap, pos, n, nk;
            bit keep[LIST_DEPTH];
            longint ai, aj, ov, un;
            kept_box_t k;
            cap = list_cap();
            if (p.score >= score_thresh)
            begin
                if (ranked_n > cap)
                    ranked_n = cap;
                pos = 0;
                while (pos < ranked_n && ranked[pos].score >= p.score)
                    pos++;
                if (pos < cap)
                begin
                    if (ranked_n < cap)
                        ranked_n++;
                    for (int i = ranked_n - 1; i > pos; i--)
                        ranked[i] = ranked[i - 1];
                    ranked[pos] = p;
                end
            end
            if (!p.frame_end)
                return;
            n = (ranked_n < cap) ? ranked_n : cap;
            nk = 0;
            for (int i = 0; i < n; i++)
            begin
                keep[i] = 1;
                ai = longint'(ranked[i].w) * longint'(ranked[i].h);
                for (int j = 0; j < i; j++)
                begin
                    if (!keep[j])
                        continue;
                    ov = overlap(ranked[i], ranked[j]);
                    aj = longint'(ranked[j].w) * longint'(ranked[j].h);
                    un = ai + aj - ov;
                    if (ov * 256 > longint'(nms_thresh) * un)
                        keep[i] = 0;
                end
                if (keep[i])
                begin
                    k.x = ranked[i].x;  k.y = ranked[i].y;
                    k.w = ranked[i].w;  k.h = ranked[i].h;
                    k.score = ranked[i].score;
                    k.cls = ranked[i].cls;
                    k.color = ranked[i].color;
                    k.rank = i[5:0];
                    k.last = 0;
                    k.none = 0;
                    pending_boxes = {pending_boxes, k};
                    nk++;
                end
            end
            if (nk == 0)
            begin
                k = '{default: '0};
                k.last = 1;
                k.none = 1;
                pending_boxes = {pending_boxes, k};
            end
            else
                pending_boxes[$].last = 1;
            ranked_n = 0;
        endfunction

        function void check_result(kept_box_t got);
            kept_box_t exp_box;
            if (pending_boxes.size() == 0)
            begin
                $error("unexpected result word, x=%0d rank=%0d", got.x, got.rank);
                errors++;
                return;
            end
            exp_box = pending_boxes.pop_front();
            if (got.x !== exp_box.x)
            begin $error("kept_x exp %0d got %0d", exp_box.x, got.x); errors++; end
            if (got.y !== exp_box.y)
            begin $error("kept_y exp %0d got %0d", exp_box.y, got.y); errors++; end
            if (got.w !== exp_box.w)
            begin $error("kept_w exp %0d got %0d", exp_box.w, got.w); errors++; end
            if (got.h !== exp_box.h)
            begin $error("kept_h exp %0d got %0d", exp_box.h, got.h); errors++; end
            if (got.score !== exp_box.score)
            begin
                $error("kept_score exp %0d got %0d", exp_box.score, got.score);
                errors++;
            end
            if (got.cls !== exp_box.cls)
            begin $error("kept_class exp %0d got %0d", exp_box.cls, got.cls); errors++; end
            if (got.color !== exp_box.color)
            begin
                $error("kept_color exp %0d got %0d", exp_box.color, got.color);
                errors++;
            end
            if (got.rank !== exp_box.rank)
            begin $error("kept_rank exp %0d got %0d", exp_box.rank, got.rank); errors++; end
            if (got.last !== exp_box.last)
            begin
                $error("last_of_run exp %0d got %0d", exp_box.last, got.last);
                errors++;
            end
            if (got.none !== exp_box.none)
            begin
                $error("none_kept exp %0d got %0d", exp_box.none, got.none);
                errors++;
            end
        endfunction
    endclass
endpackage

@@ verif/topk_sorted_box_nms_top_tb.sv @@
// Testbench top for topk_sorted_box_nms_top: drives proposals, register writes and
// result back-pressure, checks every result word. Needs tsnms_pkg, tsnms_ifs and the
// scoreboard package.
module topk_sorted_box_nms_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsnms_pkg::*;
    import tsnms_tb_sb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tsnms_in_if  prop_in();
    tsnms_out_if res_out();
    tsnms_cfg_if cfg();

    topk_sorted_box_nms_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .prop_in (prop_in),
        .res_out (res_out),
        .cfg     (cfg)
    );

    always #4 clk = ~clk;

    nms_scoreboard frame_sb = new();

    // Idle percentages for each side; the phase sequencer updates them.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // When nonzero the receiver holds ready low for this many cycles.
    int hold_off_cycles = 0;

    initial
    begin
        prop_in.valid = 1'b0;
        prop_in.box_x = '0;
        prop_in.box_y = '0;
        prop_in.box_w = '0;
        prop_in.box_h = '0;
        prop_in.score = '0;
        prop_in.class_tag = '0;
        prop_in.color_tag = '0;
        prop_in.frame_end = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        res_out.ready = 1'b0;
    end

    // Receiver: decides ready at each falling edge; long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            res_out.ready <= 1'b0;
        end
        else
            res_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every result word accepted at a rising edge goes to the checker.
    always @(posedge clk)
    begin
        kept_box_t got;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            got.x = res_out.kept_x;       got.y = res_out.kept_y;
            got.w = res_out.kept_w;       got.h = res_out.kept_h;
            got.score = res_out.kept_score;
            got.cls = res_out.kept_class;
            got.color = res_out.kept_color;
            got.rank = res_out.kept_rank;
            got.last = res_out.last_of_run;
            got.none = res_out.none_kept;
            frame_sb.check_result(got);
        end
    end

    // Drive one proposal word; returns once it has been accepted. Valid stays
    // high on return; the next idle cycle or wait_drained drops it.
    task automatic send_proposal(proposal_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            prop_in.valid <= 1'b0;
            @(negedge clk);
        end
        prop_in.valid <= 1'b1;
        prop_in.box_x <= p.x;
        prop_in.box_y <= p.y;
        prop_in.box_w <= p.w;
        prop_in.box_h <= p.h;
        prop_in.score <= p.score;
        prop_in.class_tag <= p.cls;
        prop_in.color_tag <= p.color;
        prop_in.frame_end <= p.frame_end;
        do
            @(posedge clk);
        while (!prop_in.ready);
        frame_sb.note_proposal(p);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_SCORE_THRESH: frame_sb.score_thresh = value;
            CFG_TOP_K:        frame_sb.top_k = value[TOPK_W-1:0];
            default:          frame_sb.nms_thresh = value[NMS_W-1:0];
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Block goes idle once all expected words are out; then let the
    // suppression pass of any word still in flight settle.
    task automatic wait_drained();
        prop_in.valid <= 1'b0;
        while (frame_sb.pending_boxes.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // Random proposal. Boxes mostly lie within +-60 of the origin so IoU hits
    // both sides of the threshold; a few are fully random or degenerate.
    function automatic proposal_t rand_proposal(bit fe);
        proposal_t p;
        int sel;
        sel = $urandom_range(9);
        p.x = (sel == 0) ? 16'($urandom) : 16'($signed($urandom_range(120)) - 60);
        p.y = (sel == 0) ? 16'($urandom) : 16'($signed($urandom_range(120)) - 60);
        p.w = (sel == 1) ? 13'($urandom) : (sel == 2) ? 13'd0 : 13'($urandom_range(200));
        p.h = (sel == 1) ? 13'($urandom) : (sel == 3) ? 13'd0 : 13'($urandom_range(200));
        // Coarse scores so ties happen.
        p.score = ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(15) << 12);
        p.cls = 4'($urandom);
        p.color = 2'($urandom);
        p.frame_end = fe;
        return p;
    endfunction

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++)
            send_proposal(rand_proposal(i == len - 1));
    endtask

    function automatic proposal_t mk(int x, int y, int w, int h, int s, int c, int col,
                                     bit fe);
        proposal_t p;
        p.x = 16'(x); p.y = 16'(y); p.w = 13'(w); p.h = 13'(h);
        p.score = 16'(s); p.cls = 4'(c); p.color = 2'(col); p.frame_end = fe;
        return p;
    endfunction

    int items_sent = 0;

    initial
    begin
        int len;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, ties, overlap suppression, degenerate boxes.
        write_reg(CFG_SCORE_THRESH, 16'd0);
        write_reg(CFG_NMS_THRESH, 16'd128);
        send_proposal(mk(-32768, -32768, 8191, 8191, 65535, 15, 3, 0));
        send_proposal(mk(32767, 32767, 8191, 8191, 65535, 0, 0, 0));
        send_proposal(mk(-32768, -32768, 8000, 8000, 1000, 5, 1, 0)); // overlaps first
        send_proposal(mk(0, 0, 0, 10, 500, 1, 2, 0));                  // zero area
        send_proposal(mk(0, 0, 0, 10, 400, 2, 1, 0));                  // both zero area
        send_proposal(mk(-1, -1, 1, 1, 0, 7, 2, 1));
        wait_drained();
        // Score below threshold and an empty frame.
        write_reg(CFG_SCORE_THRESH, 16'd65535);
        send_proposal(mk(5, 5, 5, 5, 65534, 3, 1, 0));
        send_proposal(mk(5, 5, 5, 5, 100, 3, 1, 1));
        wait_drained();
        // Zero top_k: nothing enters.
        write_reg(CFG_SCORE_THRESH, 16'd0);
        write_reg(CFG_TOP_K, 16'd0);
        send_proposal(mk(1, 1, 9, 9, 9000, 4, 0, 1));
        wait_drained();
        // Full list of two: low newcomer dropped, high one pushes out the tail.
        write_reg(CFG_TOP_K, 16'd2);
        write_reg(CFG_NMS_THRESH, 16'd256);
        send_proposal(mk(0, 0, 10, 10, 300, 1, 0, 0));
        send_proposal(mk(0, 0, 10, 10, 200, 2, 0, 0));
        send_proposal(mk(0, 0, 10, 10, 100, 3, 0, 0));
        send_proposal(mk(0, 0, 10, 10, 400, 4, 0, 1));
        wait_drained();
        // Threshold zero suppresses any overlap; oversized top_k; above-256 threshold.
        write_reg(CFG_NMS_THRESH, 16'd0);
        write_reg(CFG_TOP_K, 16'd127);
        send_proposal(mk(0, 0, 10, 10, 300, 1, 0, 0));
        send_proposal(mk(9, 9, 10, 10, 300, 2, 0, 0));
        send_proposal(mk(20, 20, 10, 10, 200, 3, 0, 1));
        wait_drained();
        write_reg(CFG_NMS_THRESH, 16'd511);
        send_proposal(mk(0, 0, 10, 10, 300, 1, 0, 0));
        send_proposal(mk(0, 0, 10, 10, 300, 2, 0, 1));
        wait_drained();

        // Random phases: settings vary, idling differs per phase.
        for (int ph = 0; ph < 16; ph++)
        begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            write_reg(CFG_SCORE_THRESH, (ph % 5 == 0) ? 16'd0 : 16'($urandom_range(65535)));
            write_reg(CFG_TOP_K, (ph == 3) ? 16'd64 : (ph == 7) ? 16'd1 :
                      (ph == 11) ? 16'd100 : 16'($urandom_range(1, 16)));
            write_reg(CFG_NMS_THRESH, (ph == 5) ? 16'd256 : 16'($urandom_range(256)));
            if (ph == 6)
                hold_off_cycles = 400; // result side stalls while proposals keep coming
            for (int f = 0; f < 2; f++)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
                send_frame(len);
                items_sent += len;
            end
            if (ph == 3)
            begin
                // Lower top_k mid-frame: trimmed at the next proposal.
                send_frame(1);
                wait_drained();
                for (int i = 0; i < 8; i++)
                    send_proposal(rand_proposal(0));
                wait_drained();
                write_reg(CFG_TOP_K, 16'd3);
                send_proposal(rand_proposal(1));
            end
        end
        while (items_sent < 350)
        begin
            len = $urandom_range(1, 10);
            send_frame(len);
            items_sent += len;
        end
        wait_drained();
        if (frame_sb.errors == 0 && frame_sb.pending_boxes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(20ms);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
